/* design/audio_jitter_reorder_buffer_core_assert.svh */
// assertion macros used by the jitter buffer datapath
`ifndef AUDIO_JITTER_REORDER_BUFFER_CORE_ASSERT_SVH
`define AUDIO_JITTER_REORDER_BUFFER_CORE_ASSERT_SVH

// implication checked on every edge outside reset
`define AJRB_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// invariant checked on every edge outside reset
`define AJRB_ASSERT_ALWAYS(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");

`endif

/* design/ajrb_pkg.sv */
`timescale 1ns / 1ps
package ajrb_pkg;

  localparam int unsigned Slots   = 32;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned FillW   = 6;
  localparam int unsigned SeqW    = 32;
  localparam int unsigned PayW    = 32;
  localparam int unsigned NStats  = 7;

  localparam logic [2:0] OpInsert  = 3'd0;
  localparam logic [2:0] OpPop     = 3'd1;
  localparam logic [2:0] OpDiscard = 3'd2;
  localparam logic [2:0] OpAdvance = 3'd3;
  localparam logic [2:0] OpRebuf   = 3'd4;
  localparam logic [2:0] OpClear   = 3'd5;
  localparam logic [2:0] OpStat    = 3'd6;

  localparam logic [3:0] StAccepted  = 4'd0;
  localparam logic [3:0] StLate      = 4'd1;
  localparam logic [3:0] StDuplicate = 4'd2;
  localparam logic [3:0] StOverflow  = 4'd3;
  localparam logic [3:0] StNotReady  = 4'd4;
  localparam logic [3:0] StMissing   = 4'd5;
  localparam logic [3:0] StPacket    = 4'd6;
  localparam logic [3:0] StDone      = 4'd7;
  localparam logic [3:0] StRefused   = 4'd8;

  localparam logic [2:0] CntReceived = 3'd0;
  localparam logic [2:0] CntLate     = 3'd1;
  localparam logic [2:0] CntDup      = 3'd2;
  localparam logic [2:0] CntOverflow = 3'd3;
  localparam logic [2:0] CntReorder  = 3'd4;
  localparam logic [2:0] CntLost     = 3'd5;
  localparam logic [2:0] CntLatency  = 3'd6;

  localparam logic CfgStartFill = 1'b0;
  localparam logic CfgCapacity  = 1'b1;

  typedef struct packed {
    logic [2:0]      op;
    logic [SeqW-1:0] seq;
    logic [PayW-1:0] payload;
    logic [5:0]      depth_limit;
    logic [2:0]      stat_select;
  } in_word_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [SeqW-1:0]  seq_out;
    logic [PayW-1:0]  payload_out;
    logic [5:0]       dropped_count;
    logic [31:0]      stat_value;
    logic [FillW-1:0] fill_level;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word, start a slot scan
    logic scan;      // examine slot at scan index
    logic rescan;    // restart scan for discard loop
    logic finish;    // apply result of the operation
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic need_loop;  // discard still above depth
  } dp_stat_t;

  function automatic logic seq_before(logic [SeqW-1:0] a, logic [SeqW-1:0] b);
    logic [SeqW-1:0] d;
    d = a - b;
    return d[SeqW-1];
  endfunction

  function automatic logic seq_after(logic [SeqW-1:0] a, logic [SeqW-1:0] b);
    logic [SeqW-1:0] d;
    d = a - b;
    return (d != '0) && !d[SeqW-1];
  endfunction

endpackage

/* design/ajrb_ctrl.sv */
`timescale 1ns / 1ps
module ajrb_ctrl
  import ajrb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_OUT    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        if (stat_i.need_loop) begin
          cmd_o.rescan = 1'b1;
          state_d      = S_SCAN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

/* design/ajrb_datapath.sv */
`timescale 1ns / 1ps
module ajrb_datapath
  import ajrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [5:0] cfg_data_i,
  input  in_word_t   in_word_i,
  input  dp_cmd_t    cmd_i,
  output dp_stat_t   stat_o,
  output out_word_t  out_word_o
);

  `include "audio_jitter_reorder_buffer_core_assert.svh"

  logic [5:0] start_fill_q, cap_q;

  logic [Slots-1:0] valid_q;
  logic [SeqW-1:0]  seq_mem [Slots];
  logic [PayW-1:0]  pay_mem [Slots];
  logic [SeqW-1:0]  rd_seq_q;
  logic [PayW-1:0]  rd_pay_q;

  logic             has_first_q, playing_q;
  logic [SeqW-1:0]  first_q, high_q, next_q;
  logic [31:0]      cnt_q [NStats];
  logic [FillW-1:0] fill_q;

  in_word_t         w_q;
  out_word_t        out_q;

  // scan: read data for an address arrives in the cycle after the address register holds it
  logic [SlotW:0]   addr_q;      // 0..Slots, Slots = past end
  logic [SlotW-1:0] rd_idx_q;
  logic             rd_vld_q;

  // scan results
  logic             match_q;
  logic [SlotW-1:0] match_idx_q;
  logic [PayW-1:0]  match_pay_q;
  logic             free_q;
  logic [SlotW-1:0] free_idx_q;
  logic             old_q;
  logic [SlotW-1:0] old_idx_q;
  logic [SeqW-1:0]  old_seq_q;
  logic [SeqW-1:0]  old_dist_q;
  logic [5:0]       dropped_q;

  logic [SeqW-1:0]  key;
  logic             rd_live;
  logic [SeqW-1:0]  seq_dist;
  logic [5:0]       cap_eff;
  logic             ins_ok;

  assign cap_eff = (cap_q > 6'(Slots)) ? 6'(Slots) : cap_q;

  // key for the match search: pop looks up the sequence it is about to play
  always_comb begin
    key = w_q.seq;
    if (w_q.op == OpPop) key = playing_q ? next_q : first_q;
  end

  // insert goes through: not late, not held, room left
  assign ins_ok = (w_q.op == OpInsert) && !(playing_q && seq_before(w_q.seq, next_q))
                  && !match_q && (fill_q < cap_eff);

  assign rd_live  = rd_vld_q && valid_q[rd_idx_q];
  assign seq_dist = rd_seq_q - next_q;

  assign stat_o.scan_last = rd_vld_q && (rd_idx_q == SlotW'(Slots - 1));
  assign stat_o.need_loop = (w_q.op == OpDiscard) && playing_q && old_q
                            && (fill_q - 6'd1 > w_q.depth_limit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && addr_q < (SlotW+1)'(Slots)) begin
      rd_seq_q <= seq_mem[addr_q[SlotW-1:0]];
      rd_pay_q <= pay_mem[addr_q[SlotW-1:0]];
    end
    if (cmd_i.finish && ins_ok) begin
      seq_mem[free_idx_q] <= w_q.seq;
      pay_mem[free_idx_q] <= w_q.payload;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) w_q <= in_word_i;
  end

  // result word is built at finish and held until the next finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_fill_q <= 6'd4;
      cap_q        <= 6'd32;
      valid_q      <= '0;
      has_first_q  <= 1'b0;
      playing_q    <= 1'b0;
      first_q      <= '0;
      high_q       <= '0;
      next_q       <= '0;
      fill_q       <= '0;
      for (int k = 0; k < NStats; k++) cnt_q[k] <= '0;
      addr_q       <= '0;
      rd_idx_q     <= '0;
      rd_vld_q     <= 1'b0;
      match_q      <= 1'b0;
      free_q       <= 1'b0;
      old_q        <= 1'b0;
      match_idx_q  <= '0;
      free_idx_q   <= '0;
      old_idx_q    <= '0;
      old_seq_q    <= '0;
      old_dist_q   <= '0;
      match_pay_q  <= '0;
      dropped_q    <= '0;
      out_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgStartFill) start_fill_q <= cfg_data_i;
        else cap_q <= cfg_data_i;
      end

      if (cmd_i.load || cmd_i.rescan) begin
        addr_q   <= '0;
        rd_vld_q <= 1'b0;
        match_q  <= 1'b0;
        free_q   <= 1'b0;
        old_q    <= 1'b0;
        if (cmd_i.load) dropped_q <= '0;
      end

      if (cmd_i.scan) begin
        if (addr_q < (SlotW+1)'(Slots)) begin
          addr_q   <= addr_q + 1'b1;
          rd_idx_q <= addr_q[SlotW-1:0];
          rd_vld_q <= 1'b1;
        end else begin
          rd_vld_q <= 1'b0;
        end
        if (!valid_q[addr_q[SlotW-1:0]] && !free_q && addr_q < (SlotW+1)'(Slots)) begin
          free_q     <= 1'b1;
          free_idx_q <= addr_q[SlotW-1:0];
        end
        if (rd_live && rd_seq_q == key && !match_q) begin
          match_q     <= 1'b1;
          match_idx_q <= rd_idx_q;
          match_pay_q <= rd_pay_q;
        end
        if (rd_live && (!old_q || seq_dist < old_dist_q)) begin
          old_q      <= 1'b1;
          old_idx_q  <= rd_idx_q;
          old_seq_q  <= rd_seq_q;
          old_dist_q <= seq_dist;
        end
      end

      if (cmd_i.finish) begin
        out_q               <= '0;
        out_q.status        <= StDone;
        case (w_q.op)
          OpInsert: begin
            if (playing_q && seq_before(w_q.seq, next_q)) begin
              cnt_q[CntLate] <= cnt_q[CntLate] + 1'b1;
              out_q.status   <= StLate;
            end else if (match_q) begin
              cnt_q[CntDup] <= cnt_q[CntDup] + 1'b1;
              out_q.status  <= StDuplicate;
            end else if (fill_q >= cap_eff) begin
              cnt_q[CntOverflow] <= cnt_q[CntOverflow] + 1'b1;
              out_q.status       <= StOverflow;
            end else begin
              if (!has_first_q) begin
                has_first_q <= 1'b1;
                first_q     <= w_q.seq;
                high_q      <= w_q.seq;
              end else begin
                if (!playing_q && seq_before(w_q.seq, first_q)) first_q <= w_q.seq;
                if (seq_before(w_q.seq, high_q))
                  cnt_q[CntReorder] <= cnt_q[CntReorder] + 1'b1;
                else if (seq_after(w_q.seq, high_q)) high_q <= w_q.seq;
              end
              valid_q[free_idx_q] <= 1'b1;
              fill_q              <= fill_q + 1'b1;
              cnt_q[CntReceived]  <= cnt_q[CntReceived] + 1'b1;
              out_q.status        <= StAccepted;
            end
          end
          OpPop: begin
            if (!playing_q && (!has_first_q || fill_q < start_fill_q)) begin
              out_q.status <= StNotReady;
            end else begin
              playing_q     <= 1'b1;
              out_q.seq_out <= key;
              next_q        <= key + 1'b1;
              if (match_q) begin
                out_q.payload_out    <= match_pay_q;
                valid_q[match_idx_q] <= 1'b0;
                fill_q               <= fill_q - 1'b1;
                out_q.status         <= StPacket;
              end else begin
                cnt_q[CntLost] <= cnt_q[CntLost] + 1'b1;
                out_q.status   <= StMissing;
              end
            end
          end
          OpDiscard: begin
            if (playing_q && old_q && fill_q > w_q.depth_limit) begin
              next_q               <= old_seq_q + 1'b1;
              valid_q[old_idx_q]   <= 1'b0;
              fill_q               <= fill_q - 1'b1;
              dropped_q            <= dropped_q + 1'b1;
              cnt_q[CntLatency]    <= cnt_q[CntLatency] + 1'b1;
              out_q.dropped_count  <= dropped_q + 1'b1;
            end else begin
              out_q.dropped_count <= dropped_q;
            end
          end
          OpAdvance: begin
            if (playing_q && old_q) begin
              next_q        <= old_seq_q;
              out_q.seq_out <= old_seq_q;
            end else begin
              out_q.status <= StRefused;
            end
          end
          OpRebuf, OpClear: begin
            valid_q     <= '0;
            fill_q      <= '0;
            has_first_q <= 1'b0;
            playing_q   <= 1'b0;
            first_q     <= '0;
            high_q      <= '0;
            next_q      <= '0;
            if (w_q.op == OpClear)
              for (int k = 0; k < NStats; k++) cnt_q[k] <= '0;
          end
          OpStat: begin
            if (w_q.stat_select != 3'd7) out_q.stat_value <= cnt_q[w_q.stat_select];
            else out_q.status <= StRefused;
          end
          default: out_q.status <= StRefused;
        endcase
      end
    end
  end

  always_comb begin
    out_word_o            = out_q;
    out_word_o.fill_level = fill_q;
  end

  `AJRB_ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, fill_q <= 6'(Slots))
  `AJRB_ASSERT_ALWAYS(a_fill_pop, clk_i, rst_ni,
                      $countones(valid_q) == 32'(fill_q))
  `AJRB_ASSERT_IMP(a_play_first, clk_i, rst_ni, playing_q, has_first_q)

endmodule

/* design/audio_jitter_reorder_buffer_core.sv */
`timescale 1ns / 1ps
// channel | signals                          | accepted when
// in      | in_valid_i/in_ready_o, in_word_i | in_valid_i && in_ready_o
// out     | out_valid_o, out_word_o          | out_valid_o && out_ready_i
// cfg     | cfg_we_i, cfg_idx_i, cfg_data_i  | cfg_we_i
// An item passes through the accept cycle, a scan of the 32-entry slot table,
// a finish state and a result state that waits for out_ready_i.
// Discard repeats scan and finish for each dropped entry after the first.
// One item is in flight; the next is taken the cycle after its result is accepted,
// so an output stall delays the next item.
// Reset clears all control state and counters at once; no clearing pass.
module audio_jitter_reorder_buffer_core
  import ajrb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [5:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ajrb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o (cmd), .stat_i (stat)
  );

  ajrb_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_word_i,
    .cmd_i (cmd), .stat_o (stat), .out_word_o
  );

endmodule
